### rtl/phcd_pkg.sv
package phcd_pkg;

    // channel and led frame widths
    localparam int CHAN_W   = 12;
    localparam int ROW_W    = 16;
    localparam int OUT_ROWS = 8;

    // decay counter
    localparam int          COUNT_W     = 7;
    localparam logic [6:0]  PEAK_RELOAD = 7'd79;

    // full-scale channel value, 2**CHAN_W - 1
    localparam int FULL_SCALE = 4095;

    // defaults for the top level parameters
    localparam int DEF_NUM_COLUMNS = 16;
    localparam int DEF_NUM_ROWS    = 8;

    // row of a counter: count / 10, as count * 205 >> 11 (exact below 1029)
    localparam int ROW_RECIP = 205;
    localparam int ROW_SHIFT = 11;
    localparam int ROW_IDX_W = 4;

    function automatic logic [ROW_IDX_W-1:0] row_of(input logic [COUNT_W-1:0] count);
        logic [14:0] prod;
        prod = 15'(count) * 15'(ROW_RECIP);
        return prod[ROW_SHIFT +: ROW_IDX_W];
    endfunction

endpackage

### rtl/phcd_in_if.sv
interface phcd_in_if;
    logic                       valid;
    logic                       ready;
    logic [phcd_pkg::CHAN_W-1:0] chan_a;
    logic [phcd_pkg::CHAN_W-1:0] chan_b;
    logic [phcd_pkg::CHAN_W-1:0] chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c,
                    input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c,
                    output ready);
endinterface

### rtl/phcd_out_if.sv
interface phcd_out_if;
    logic                       valid;
    logic                       ready;
    logic [phcd_pkg::ROW_W-1:0] row0;
    logic [phcd_pkg::ROW_W-1:0] row1;
    logic [phcd_pkg::ROW_W-1:0] row2;
    logic [phcd_pkg::ROW_W-1:0] row3;
    logic [phcd_pkg::ROW_W-1:0] row4;
    logic [phcd_pkg::ROW_W-1:0] row5;
    logic [phcd_pkg::ROW_W-1:0] row6;
    logic [phcd_pkg::ROW_W-1:0] row7;
    logic                       too_big;

    modport source (output valid, output row0, output row1, output row2, output row3,
                    output row4, output row5, output row6, output row7,
                    output too_big, input ready);
    modport sink   (input valid, input row0, input row1, input row2, input row3,
                    input row4, input row5, input row6, input row7,
                    input too_big, output ready);
endinterface

### rtl/phcd_column_map.sv
module phcd_column_map #(
    parameter int NUM_COLUMNS = phcd_pkg::DEF_NUM_COLUMNS
) (
    input  logic [phcd_pkg::CHAN_W-1:0]        value,
    output logic [$clog2(NUM_COLUMNS)-1:0]     column,
    output logic                               clamped
);
    import phcd_pkg::*;

    localparam int COL_W  = $clog2(NUM_COLUMNS);
    localparam int Q_W    = $clog2(NUM_COLUMNS + 1);
    localparam int PROD_W = CHAN_W + Q_W;
    localparam int REM_W  = CHAN_W + 1;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    quot_est;
    logic [REM_W-1:0]  rem;
    logic [Q_W-1:0]    quot;

    // value * columns / 4095: p = q0*4096 + lo = q0*4095 + (lo + q0),
    // and lo + q0 stays below twice the divisor, so one correction step
    always_comb
    begin
        prod     = PROD_W'(value) * PROD_W'(NUM_COLUMNS);
        quot_est = prod[PROD_W-1:CHAN_W];
        rem      = REM_W'(prod[CHAN_W-1:0]) + REM_W'(quot_est);
        quot     = quot_est + Q_W'(rem >= REM_W'(FULL_SCALE));
    end

    // full-scale value lands one past the last column
    always_comb
    begin
        if (quot >= Q_W'(NUM_COLUMNS))
        begin
            column  = COL_W'(NUM_COLUMNS - 1);
            clamped = 1'b1;
        end
        else
        begin
            column  = quot[COL_W-1:0];
            clamped = 1'b0;
        end
    end

endmodule

### rtl/peak_hold_column_display.sv
// peak-hold column display for three channels
//
// samples (sink): one beat carries chan_a, chan_b and chan_c, 12 bits each.
// leds (source): one beat per input beat with rows row0 (bottom) to row7
// (top), bit x lighting column x, and too_big when a full-scale channel
// was clamped onto the last column.
//
// every column keeps a decay counter; each frame lights row count/10 of
// each column and steps its counter down, while columns hit by a channel
// reload to 79 and light over their full height.
//
// a beat accepted into the input register moves on to the result register
// when that register is empty or leds.ready is high; leds.valid rises with
// the move, and the led beat leaves the result register on leds.ready.
// throughput: one beat per cycle while leds.ready stays high, set by the single
// pass from input register through the counter update into the result register.
// reset clears all decay counters and empties both registers. when the
// receiver stalls the result register holds, the input register takes one
// more beat, and then samples.ready drops until leds.ready returns.
module peak_hold_column_display #(
    parameter int NUM_COLUMNS = phcd_pkg::DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = phcd_pkg::DEF_NUM_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    phcd_in_if.sink   samples,
    phcd_out_if.source leds
);
    import phcd_pkg::*;

    localparam int COL_W = $clog2(NUM_COLUMNS);

    // input register
    logic              s1_valid_reg;
    logic [CHAN_W-1:0] chan_a_reg;
    logic [CHAN_W-1:0] chan_b_reg;
    logic [CHAN_W-1:0] chan_c_reg;

    // result register
    logic              out_valid_reg;
    logic [ROW_W-1:0]  row_reg [OUT_ROWS];
    logic              too_big_reg;
    logic [ROW_W-1:0]  row_next [OUT_ROWS];
    logic              too_big_next;

    // decay counters
    logic [COUNT_W-1:0] count_reg  [NUM_COLUMNS];
    logic [COUNT_W-1:0] count_next [NUM_COLUMNS];

    logic                   advance;
    logic [COL_W-1:0]       col_a;
    logic [COL_W-1:0]       col_b;
    logic [COL_W-1:0]       col_c;
    logic                   clamp_a;
    logic                   clamp_b;
    logic                   clamp_c;
    logic [NUM_COLUMNS-1:0] hit;
    logic [NUM_COLUMNS-1:0] lit [NUM_ROWS];

    // handshake
    assign advance       = s1_valid_reg && (!out_valid_reg || leds.ready);
    assign samples.ready = !s1_valid_reg || advance;

    // channel to column mapping
    phcd_column_map #(.NUM_COLUMNS(NUM_COLUMNS)) u_map_a
    (
        .value   (chan_a_reg),
        .column  (col_a),
        .clamped (clamp_a)
    );

    phcd_column_map #(.NUM_COLUMNS(NUM_COLUMNS)) u_map_b
    (
        .value   (chan_b_reg),
        .column  (col_b),
        .clamped (clamp_b)
    );

    phcd_column_map #(.NUM_COLUMNS(NUM_COLUMNS)) u_map_c
    (
        .value   (chan_c_reg),
        .column  (col_c),
        .clamped (clamp_c)
    );

    assign too_big_next = clamp_a || clamp_b || clamp_c;

    // per-column decay row, counter step and peak reload
    always_comb
    begin
        logic [ROW_IDX_W-1:0] r;
        for (int y = 0; y < NUM_ROWS; y++)
        begin
            lit[y] = '0;
        end
        for (int x = 0; x < NUM_COLUMNS; x++)
        begin
            hit[x] = (col_a == COL_W'(x)) || (col_b == COL_W'(x)) || (col_c == COL_W'(x));
            r = row_of(count_reg[x]);
            if ({1'b0, r} > 5'(NUM_ROWS - 1))
            begin
                r = ROW_IDX_W'(NUM_ROWS - 1);
            end
            for (int y = 0; y < NUM_ROWS; y++)
            begin
                lit[y][x] = (r == ROW_IDX_W'(y)) || hit[x];
            end
            if (hit[x])
            begin
                count_next[x] = PEAK_RELOAD;
            end
            else if (count_reg[x] != '0)
            begin
                count_next[x] = count_reg[x] - COUNT_W'(1);
            end
            else
            begin
                count_next[x] = '0;
            end
        end
    end

    // fit the lit matrix onto the fixed output rows
    for (genvar gy = 0; gy < OUT_ROWS; gy++)
    begin : g_row
        for (genvar gx = 0; gx < ROW_W; gx++)
        begin : g_bit
            if (gy < NUM_ROWS && gx < NUM_COLUMNS)
            begin : g_used
                assign row_next[gy][gx] = lit[gy][gx];
            end
            else
            begin : g_unused
                assign row_next[gy][gx] = 1'b0;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            chan_a_reg <= samples.chan_a;
            chan_b_reg <= samples.chan_b;
            chan_c_reg <= samples.chan_c;
        end
    end

    // decay counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int x = 0; x < NUM_COLUMNS; x++)
            begin
                count_reg[x] <= '0;
            end
        end
        else if (advance)
        begin
            for (int x = 0; x < NUM_COLUMNS; x++)
            begin
                count_reg[x] <= count_next[x];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (leds.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int y = 0; y < OUT_ROWS; y++)
            begin
                row_reg[y] <= row_next[y];
            end
            too_big_reg <= too_big_next;
        end
    end

    // output beat
    assign leds.valid   = out_valid_reg;
    assign leds.row0    = row_reg[0];
    assign leds.row1    = row_reg[1];
    assign leds.row2    = row_reg[2];
    assign leds.row3    = row_reg[3];
    assign leds.row4    = row_reg[4];
    assign leds.row5    = row_reg[5];
    assign leds.row6    = row_reg[6];
    assign leds.row7    = row_reg[7];
    assign leds.too_big = too_big_reg;

endmodule
